// ===== design/lls_pkg.sv =====
// Shared constants, command codes and control/status structs for the linked-list
// segment mover. No dependencies; used by every other file of the block.

package lls_pkg;

   // Width of every element-number field on the ports.
   localparam int DATA_W = 7;

   // Default capacity of the link tables.
   localparam int MAX_ITEMS_DEF = 64;

   // Request command codes.
   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_MOVE = 2'd1;
   localparam logic [1:0] CMD_DUMP = 2'd2;

   // Register index of list_length, taken from address bit 2.
   localparam logic CSR_LIST_LENGTH = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_args;
      logic sweep_start;
      logic sweep_step;
      logic mv_read;
      logic mv_unlink;
      logic mv_splice_a;
      logic mv_splice_b;
      logic dump_start;
      logic dump_emit;
   } lls_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic move_ok;
      logic head_zero;
      logic sweep_last;
      logic dump_final;
      logic rsp_free;
   } lls_sts_type;

endpackage

// ===== design/lls_datapath.sv =====
// Datapath of the linked-list segment mover: forward and backward link memories,
// head pointer, run arguments, dump walker and the result register.
// Depends on lls_pkg; driven by commands from lls_controller.

module lls_datapath #(
   parameter int MAX_ITEMS = lls_pkg::MAX_ITEMS_DEF,
   localparam int IW = $clog2(MAX_ITEMS + 1),
   localparam int DEPTH = MAX_ITEMS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lls_pkg::lls_cmd_type      cmd,
   output lls_pkg::lls_sts_type      sts,
   input  logic [IW-1:0]             list_length,
   input  logic [lls_pkg::DATA_W-1:0] req_first,
   input  logic [lls_pkg::DATA_W-1:0] req_last,
   input  logic [lls_pkg::DATA_W-1:0] req_anchor,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [lls_pkg::DATA_W-1:0] rsp_element,
   output logic                      rsp_last
);

   logic [IW-1:0] fwd_link_ff [DEPTH];
   logic [IW-1:0] bwd_link_ff [DEPTH];
   logic [IW-1:0] fwd_rd_ff, bwd_rd_ff;

   logic          fwd_we, bwd_we, fwd_re, bwd_re;
   logic [IW-1:0] fwd_wa, fwd_wd, bwd_wa, bwd_wd, fwd_ra, bwd_ra;

   logic [IW-1:0] first_ff, first_in, last_ff, last_in, anchor_ff, anchor_in;
   logic [IW-1:0] after_ff, after_in;
   logic          byp_ff, byp_in;
   logic [IW-1:0] head_ff, head_in, sweep_ff, sweep_in, cur_ff, cur_in, cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [IW-1:0] rsp_elem_ff, rsp_elem_in;

   logic [lls_pkg::DATA_W-1:0] len_wide;
   logic [IW-1:0] prev_elem, after, follow, nxt;
   logic          dump_final;

   assign len_wide  = lls_pkg::DATA_W'(list_length);
   assign prev_elem = bwd_rd_ff;
   assign after     = fwd_rd_ff;
   assign nxt       = fwd_rd_ff;
   // The anchor read overlaps the unlink write; forward the new link when they meet.
   assign follow   = byp_ff ? after_ff : fwd_rd_ff;
   assign dump_final = (nxt == '0) ||
                       ((IW + 1)'(cnt_ff) + (IW + 1)'(1) == (IW + 1)'(list_length));

   always_comb begin
      sts.move_ok    = (req_first != '0) && (req_first <= len_wide) &&
                       (req_last != '0) && (req_last <= len_wide) &&
                       (req_anchor <= len_wide);
      sts.head_zero  = (head_ff == '0);
      sts.sweep_last = (sweep_ff == list_length);
      sts.dump_final = dump_final;
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      fwd_we = 1'b0;  fwd_wa = first_ff;  fwd_wd = '0;
      bwd_we = 1'b0;  bwd_wa = first_ff;  bwd_wd = '0;
      fwd_re = 1'b0;  fwd_ra = cur_ff;
      bwd_re = 1'b0;  bwd_ra = first_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      anchor_in = anchor_ff;
      after_in  = after_ff;
      byp_in    = byp_ff;
      head_in   = head_ff;
      sweep_in  = sweep_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.load_args) begin
         first_in  = IW'(req_first);
         last_in   = IW'(req_last);
         anchor_in = IW'(req_anchor);
      end
      if (cmd.sweep_start) begin
         sweep_in = IW'(1);
         head_in  = IW'(1);
      end
      if (cmd.sweep_step) begin
         fwd_we   = 1'b1;
         fwd_wa   = sweep_ff;
         fwd_wd   = (sweep_ff == list_length) ? '0 : sweep_ff + IW'(1);
         bwd_we   = 1'b1;
         bwd_wa   = sweep_ff;
         bwd_wd   = sweep_ff - IW'(1);
         sweep_in = sweep_ff + IW'(1);
      end
      if (cmd.mv_read) begin
         bwd_re = 1'b1;
         bwd_ra = first_ff;
         fwd_re = 1'b1;
         fwd_ra = last_ff;
      end
      if (cmd.mv_unlink) begin
         after_in = after;
         if (prev_elem != '0) begin
            fwd_we = 1'b1;
            fwd_wa = prev_elem;
            fwd_wd = after;
         end else begin
            head_in = after;
         end
         if (after != '0) begin
            bwd_we = 1'b1;
            bwd_wa = after;
            bwd_wd = prev_elem;
         end
         fwd_re = 1'b1;
         fwd_ra = anchor_ff;
         byp_in = (prev_elem != '0) && (prev_elem == anchor_ff);
      end
      if (cmd.mv_splice_a) begin
         fwd_we = 1'b1;
         if (anchor_ff != '0) begin
            fwd_wa = anchor_ff;
            fwd_wd = first_ff;
         end else begin
            fwd_wa = last_ff;
            fwd_wd = head_ff;
         end
         bwd_we = 1'b1;
         bwd_wa = first_ff;
         bwd_wd = anchor_ff;
      end
      if (cmd.mv_splice_b) begin
         if (anchor_ff != '0) begin
            fwd_we = 1'b1;
            fwd_wa = last_ff;
            fwd_wd = follow;
            bwd_we = (follow != '0);
            bwd_wa = follow;
            bwd_wd = last_ff;
         end else begin
            bwd_we  = (head_ff != '0);
            bwd_wa  = head_ff;
            bwd_wd  = last_ff;
            head_in = first_ff;
         end
      end
      if (cmd.dump_start) begin
         fwd_re = 1'b1;
         fwd_ra = head_ff;
         cur_in = head_ff;
         cnt_in = '0;
      end
      if (cmd.dump_emit) begin
         rsp_valid_in = 1'b1;
         rsp_elem_in  = cur_ff;
         rsp_last_in  = dump_final;
         cur_in = nxt;
         cnt_in = cnt_ff + IW'(1);
         fwd_re = 1'b1;
         fwd_ra = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_link_ff[fwd_wa] <= fwd_wd;
      end
      if (fwd_re) begin
         fwd_rd_ff <= fwd_link_ff[fwd_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (bwd_we) begin
         bwd_link_ff[bwd_wa] <= bwd_wd;
      end
      if (bwd_re) begin
         bwd_rd_ff <= bwd_link_ff[bwd_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= IW'(1);
         sweep_ff     <= IW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff    <= first_in;
      last_ff     <= last_in;
      anchor_ff   <= anchor_in;
      after_ff    <= after_in;
      byp_ff      <= byp_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_element = lls_pkg::DATA_W'(rsp_elem_ff);
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== design/lls_controller.sv =====
// Controller state machine of the linked-list segment mover: request decode,
// table rebuild sweep, the four-step move sequence and the dump walk.
// Depends on lls_pkg; drives lls_datapath through command and status structs.

module lls_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cfg_wr,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_cmd,
   output logic                 req_tready,
   input  lls_pkg::lls_sts_type sts,
   output lls_pkg::lls_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_MV_READ,
      S_MV_UNLINK,
      S_MV_SPLICE_A,
      S_MV_SPLICE_B,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;

   // A register write in the same cycle wins over a request.
   assign req_tready = (state_ff == S_IDLE) && !cfg_wr;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (cfg_wr) begin
         cmd.sweep_start = 1'b1;
         state_in        = S_SWEEP;
      end else begin
         case (state_ff)
            S_SWEEP: begin
               cmd.sweep_step = 1'b1;
               if (sts.sweep_last) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  case (req_cmd)
                     lls_pkg::CMD_INIT: begin
                        cmd.sweep_start = 1'b1;
                        state_in        = S_SWEEP;
                     end
                     lls_pkg::CMD_MOVE: begin
                        if (sts.move_ok) begin
                           cmd.load_args = 1'b1;
                           state_in      = S_MV_READ;
                        end
                     end
                     lls_pkg::CMD_DUMP: begin
                        if (!sts.head_zero) begin
                           cmd.dump_start = 1'b1;
                           state_in       = S_DUMP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MV_READ: begin
               cmd.mv_read = 1'b1;
               state_in    = S_MV_UNLINK;
            end
            S_MV_UNLINK: begin
               cmd.mv_unlink = 1'b1;
               state_in      = S_MV_SPLICE_A;
            end
            S_MV_SPLICE_A: begin
               cmd.mv_splice_a = 1'b1;
               state_in        = S_MV_SPLICE_B;
            end
            S_MV_SPLICE_B: begin
               cmd.mv_splice_b = 1'b1;
               state_in        = S_IDLE;
            end
            S_DUMP: begin
               if (sts.rsp_free) begin
                  cmd.dump_emit = 1'b1;
                  if (sts.dump_final) begin
                     state_in = S_IDLE;
                  end
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_emit |-> sts.rsp_free)
      else $error("dump result issued while the result register is occupied");

   a_splice_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MV_SPLICE_A && !cfg_wr) |=> (state_ff == S_MV_SPLICE_B))
      else $error("second splice step skipped");

   a_bad_move_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_cmd == lls_pkg::CMD_MOVE && !sts.move_ok)
      |=> (state_ff == S_IDLE))
      else $error("move with an out-of-range index was started");

   a_dump_ends_on_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP && !cfg_wr && !cmd.dump_emit) |=> (state_ff == S_DUMP))
      else $error("dump walk left before its final result");

endmodule

// ===== design/linked_list_segment_mover.sv =====
// Move request: the next request is taken once the four move steps have run;
// no result.
// Init request and list_length write: rebuild sweep over elements 1..list_length, one link per cycle.
// Dump request: the head link is read, then results leave the result register one per cycle
// while rsp_tready is high, set by one forward-link memory read per element.
// Reset is synchronous; after it the block runs a rebuild sweep over all MAX_ITEMS elements
// with req_tready low, then holds the list 1..MAX_ITEMS.

module linked_list_segment_mover #(
   parameter int MAX_ITEMS = lls_pkg::MAX_ITEMS_DEF,
   localparam int IW = $clog2(MAX_ITEMS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd[1:0], seg_first[8:2], seg_last[15:9], anchor[22:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // element[6:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DW = lls_pkg::DATA_W;

   logic [IW-1:0] len_ff, len_in;
   logic [DW-1:0] wr_val;
   logic          cfg_wr;
   logic [DW-1:0] element;

   lls_pkg::lls_cmd_type cmd;
   lls_pkg::lls_sts_type sts;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == lls_pkg::CSR_LIST_LENGTH);
   assign wr_val = csr_pwdata[DW-1:0];

   // Only pwdata[6:0] is taken: a zero there is stored as one and anything above capacity as capacity.
   always_comb begin
      len_in = len_ff;
      if (cfg_wr) begin
         if (wr_val == '0) begin
            len_in = IW'(1);
         end else if (wr_val > DW'(MAX_ITEMS)) begin
            len_in = IW'(MAX_ITEMS);
         end else begin
            len_in = IW'(wr_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= IW'(MAX_ITEMS);
      end else begin
         len_ff <= len_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == lls_pkg::CSR_LIST_LENGTH) ? 32'(len_ff) : '0;

   lls_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tdata[1:0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lls_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .list_length (len_ff),
      .req_first   (req_tdata[8:2]),
      .req_last    (req_tdata[15:9]),
      .req_anchor  (req_tdata[22:16]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_element (element),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, element};

endmodule

// ===== tb/sv/tb_linked_list_segment_mover.sv =====
// Self-checking testbench for linked_list_segment_mover: drives init, move and dump requests,
// predicts the dumped list order and checks every result transfer on the response stream.
// Depends on lls_pkg and the linked_list_segment_mover RTL.
`timescale 1ns / 100ps

module tb_linked_list_segment_mover;

   localparam int LIST_CAP = lls_pkg::MAX_ITEMS_DEF;
   localparam int LIVE = 0;
   localparam int PLAN = 1;
   localparam logic [1:0] CMD_INIT = lls_pkg::CMD_INIT;
   localparam logic [1:0] CMD_MOVE = lls_pkg::CMD_MOVE;
   localparam logic [1:0] CMD_DUMP = lls_pkg::CMD_DUMP;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] LIST_LENGTH_ADDR = {lls_pkg::CSR_LIST_LENGTH, 2'b00};

   typedef struct packed {
      logic [6:0] anchor;
      logic [6:0] seg_last;
      logic [6:0] seg_first;
      logic [1:0] cmd;
   } list_request_type;

   typedef struct {
      logic [6:0] element;
      logic       last;
   } dump_entry_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_LONG_STALL} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // cmd[1:0], seg_first[8:2], seg_last[15:9], anchor[22:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // element[6:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Two copies of the list: LIVE follows accepted transfers, PLAN follows the generator.
   logic [6:0]    fwd_link [0:1][0:LIST_CAP];
   logic [6:0]    bwd_link [0:1][0:LIST_CAP];
   int            head_elem [0:1];
   int            list_len [0:1];
   logic [6:0]    plan_walk [0:LIST_CAP-1];
   int            walk_len;

   list_request_type pending_requests[$];
   dump_entry_type   expected_dump[$];
   dump_entry_type   want;
   int               mismatches = 0;

   int               burst_left = 1;
   int               gap_left = 0;
   logic             sending;
   int               rx_cycle = 0;
   stall_mode_type   rx_mode = RX_OPEN;
   logic             rx_ready;

   linked_list_segment_mover i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int slot(input int i);
      return (i <= LIST_CAP) ? i : 0;
   endfunction

   function automatic void list_rebuild(input int m);
      for (int i = 0; i <= LIST_CAP; i++) begin
         fwd_link[m][i] = '0;
         bwd_link[m][i] = '0;
      end
      for (int i = 1; i <= list_len[m]; i++) begin
         fwd_link[m][i] = (i < list_len[m]) ? 7'(i + 1) : 7'd0;
         bwd_link[m][i] = 7'(i - 1);
      end
      head_elem[m] = 1;
   endfunction

   function automatic void set_list_length(input int m, input logic [31:0] value);
      int n;
      n = value[6:0];
      if (n == 0) n = 1;
      if (n > LIST_CAP) n = LIST_CAP;
      list_len[m] = n;
      list_rebuild(m);
   endfunction

   // Applies one request to list copy m. A dump on LIVE queues the expected results;
   // on PLAN it records the walk order for the stimulus generator instead.
   function automatic void list_step(input int m, input list_request_type r);
      int             first, lastel, anchor;
      int             prev_elem, after, follow;
      int             count, cur, nxt;
      logic           fin;
      dump_entry_type entry;
      first = r.seg_first;
      lastel = r.seg_last;
      anchor = r.anchor;
      case (r.cmd)
         CMD_INIT: list_rebuild(m);
         CMD_MOVE: begin
            if (first != 0 && first <= list_len[m] && lastel != 0 && lastel <= list_len[m] &&
                anchor <= list_len[m]) begin
               prev_elem = bwd_link[m][slot(first)];
               after = fwd_link[m][slot(lastel)];
               if (prev_elem != 0) fwd_link[m][slot(prev_elem)] = 7'(after);
               else head_elem[m] = after;
               if (after != 0) bwd_link[m][slot(after)] = 7'(prev_elem);
               if (anchor == 0) begin
                  bwd_link[m][slot(first)] = '0;
                  fwd_link[m][slot(lastel)] = 7'(head_elem[m]);
                  if (head_elem[m] != 0) bwd_link[m][slot(head_elem[m])] = 7'(lastel);
                  head_elem[m] = first;
               end else begin
                  follow = fwd_link[m][slot(anchor)];
                  fwd_link[m][slot(anchor)] = 7'(first);
                  bwd_link[m][slot(first)] = 7'(anchor);
                  fwd_link[m][slot(lastel)] = 7'(follow);
                  if (follow != 0) bwd_link[m][slot(follow)] = 7'(lastel);
               end
            end
         end
         CMD_DUMP: begin
            count = 0;
            cur = slot(head_elem[m]);
            fin = 1'b0;
            while (cur != 0 && count < list_len[m] && !fin) begin
               nxt = slot(fwd_link[m][cur]);
               fin = (nxt == 0) || (count + 1 == list_len[m]);
               if (m == LIVE) begin
                  entry.element = 7'(cur);
                  entry.last = fin;
                  expected_dump.push_back(entry);
               end else begin
                  plan_walk[count] = 7'(cur);
               end
               count++;
               cur = nxt;
            end
            if (m == PLAN) walk_len = count;
         end
         default: ;
      endcase
   endfunction

   function automatic list_request_type make_request(input logic [1:0] cmd, input int first,
                                                     input int lastel, input int anchor);
      list_request_type r;
      r.cmd = cmd;
      r.seg_first = 7'(first);
      r.seg_last = 7'(lastel);
      r.anchor = 7'(anchor);
      return r;
   endfunction

   task automatic add_request(input list_request_type r);
      list_step(PLAN, r);
      pending_requests.push_back(r);
   endtask

   task automatic drain;
      while (pending_requests.size() != 0 || req_tvalid || expected_dump.size() != 0)
         @(posedge clock);
   endtask

   // Register writes only go out once the block has gone quiet; the extra wait covers a
   // rebuild sweep still running after the last result.
   task automatic write_list_length(input logic [31:0] value);
      drain();
      repeat (80) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= LIST_LENGTH_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      set_list_length(LIVE, value);
      set_list_length(PLAN, value);
   endtask

   task automatic run_phase(input int n);
      int kind, p, q, outside, k, pos, anchor;
      for (int i = 0; i < n; i++) begin
         // Refresh the planned order so moves can pick well-formed runs from it.
         list_step(PLAN, make_request(CMD_DUMP, 0, 0, 0));
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            if (walk_len == 0) begin
               add_request(make_request(CMD_INIT, 0, 0, 0));
            end else begin
               p = $urandom_range(0, walk_len - 1);
               if ($urandom_range(0, 3) == 0) q = $urandom_range(p, walk_len - 1);
               else q = $urandom_range(p, (p + 2 < walk_len) ? p + 2 : walk_len - 1);
               outside = walk_len - (q - p + 1);
               anchor = 0;
               if (outside != 0 && $urandom_range(0, 4) != 0) begin
                  k = $urandom_range(0, outside - 1);
                  pos = (k < p) ? k : k + q - p + 1;
                  anchor = plan_walk[pos];
               end
               add_request(make_request(CMD_MOVE, plan_walk[p], plan_walk[q], anchor));
            end
         end else if (kind < 70) begin
            add_request(make_request(CMD_DUMP, $urandom_range(0, 127), $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
         end else if (kind < 75) begin
            add_request(make_request(CMD_INIT, $urandom_range(0, 127), $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
         end else if (kind < 83) begin
            add_request(make_request(CMD_MOVE, $urandom_range(0, 127), $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
         end else if (kind < 91) begin
            if (walk_len >= 2) begin
               p = $urandom_range(0, walk_len - 2);
               q = $urandom_range(p + 1, walk_len - 1);
               if ($urandom_range(0, 1) == 0) begin
                  anchor = ($urandom_range(0, 1) == 0) ? 0 :
                           plan_walk[$urandom_range(0, walk_len - 1)];
                  add_request(make_request(CMD_MOVE, plan_walk[q], plan_walk[p], anchor));
               end else begin
                  add_request(make_request(CMD_MOVE, plan_walk[p], plan_walk[q],
                                           plan_walk[$urandom_range(p, q)]));
               end
               add_request(make_request(CMD_DUMP, 0, 0, 0));
               add_request(make_request(CMD_INIT, 0, 0, 0));
            end
         end else if (kind < 96) begin
            add_request(make_request(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
         end else begin
            add_request(list_request_type'(23'($urandom)));
         end
      end
   endtask

   // Request driver: bursts of random length with random gaps, fed from pending_requests.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready === 1'b1) begin
            list_step(LIVE, pending_requests.pop_front());
         end
         if (!(req_tvalid && req_tready !== 1'b1)) begin
            sending = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               sending = 1'b1;
               req_tdata <= {1'b0, pending_requests[0]};
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_tvalid <= sending;
         end
      end
   end

   // Result monitor and receiver stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_dump.size() == 0) begin
            $error("unexpected result transfer: element %0d last %0b", rsp_tdata[6:0],
                   rsp_tlast);
            mismatches++;
         end else begin
            want = expected_dump.pop_front();
            if (rsp_tdata[6:0] !== want.element) begin
               $error("element: expected %0d, actual %0d", want.element, rsp_tdata[6:0]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_mode = stall_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:   rx_ready = 1'b1;
         RX_RANDOM: rx_ready = 1'($urandom_range(0, 1));
         RX_SPARSE: rx_ready = (rx_cycle % 4 == 0);
         default:   rx_ready = (rx_cycle % 24) >= 20;
      endcase
      rsp_tready <= rx_ready;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      set_list_length(LIVE, LIST_CAP);
      set_list_length(PLAN, LIST_CAP);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the full-length list left by reset.
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      add_request(make_request(CMD_MOVE, 5, 9, 0));
      add_request(make_request(CMD_MOVE, 64, 64, 0));
      add_request(make_request(CMD_MOVE, 64, 64, 63));
      add_request(make_request(CMD_MOVE, 1, 4, 9));
      add_request(make_request(CMD_MOVE, 10, 64, 0));
      add_request(make_request(CMD_MOVE, 2, 3, 64));
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      // Out-of-range indexes and the unused command must leave the list alone.
      add_request(make_request(CMD_MOVE, 0, 3, 0));
      add_request(make_request(CMD_MOVE, 65, 65, 0));
      add_request(make_request(CMD_MOVE, 3, 3, 65));
      add_request(make_request(CMD_MOVE, 127, 127, 127));
      add_request(make_request(CMD_UNUSED, 127, 127, 127));
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      // A misordered run and an anchor inside the run break the list; dumps must cope.
      add_request(make_request(CMD_MOVE, 4, 10, 0));
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      add_request(make_request(CMD_INIT, 0, 0, 0));
      add_request(make_request(CMD_MOVE, 1, 5, 3));
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      add_request(make_request(CMD_INIT, 0, 0, 0));
      add_request(make_request(CMD_DUMP, 0, 0, 0));
      add_request(make_request(CMD_MOVE, 1, 64, 0));
      add_request(make_request(CMD_DUMP, 0, 0, 0));

      write_list_length(32'd8);
      run_phase(60);
      write_list_length(32'd1);
      run_phase(20);
      write_list_length(32'd0);
      run_phase(15);
      write_list_length(32'd2);
      run_phase(30);
      write_list_length(32'd127);
      run_phase(40);
      drain();
      run_phase(40);
      write_list_length($urandom_range(3, 63));
      run_phase(45);
      write_list_length(32'd64);
      run_phase(35);

      drain();
      repeat (100) @(posedge clock);
      if (expected_dump.size() != 0) begin
         $error("%0d expected results never arrived", expected_dump.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
